[rtl/rba_pkg.sv]
// Shared types, codes and constants of the replacement block allocator.
package rba_pkg;

  localparam int unsigned RBA_TABLE_DEPTH       = 1024;
  localparam int unsigned RBA_ENTRIES_PER_BLOCK = 128;

  // Arithmetic widths: 32-bit block / 16-bit track size, times 8-bit spares.
  localparam int unsigned BLK_W   = 32;
  localparam int unsigned TRK_W   = 16;
  localparam int unsigned SPT_W   = 8;
  localparam int unsigned SPARE_W = BLK_W + SPT_W;
  localparam int unsigned EIDX_W  = 10;

  // Input word layout (tdata); cmd travels in tuser
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_REPLACE = 1'b1
  } rba_cmd_e;

  typedef enum logic [1:0] {
    CODE_FREE      = 2'd0,
    CODE_PRIMARY   = 2'd1,
    CODE_ALTERNATE = 2'd2,
    CODE_UNUSABLE  = 2'd3
  } rba_code_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NO_SPARE = 2'd2
  } rba_status_e;

  typedef enum logic [1:0] {
    CFG_DISK_SIZE  = 2'd0,
    CFG_TRACK_SIZE = 2'd1,
    CFG_SPARES     = 2'd2
  } rba_cfg_e;

  typedef struct packed {
    logic [1:0]       code;
    logic [BLK_W-1:0] owner;
  } rba_entry_t;

  // Request from the control path to the table engine
  typedef struct packed {
    logic               is_write;
    logic [EIDX_W-1:0]  widx;
    logic [1:0]         wcode;
    logic [BLK_W-1:0]   wblock;
    logic [BLK_W-1:0]   bad;
    logic [SPARE_W-1:0] prbn;
    logic [SPARE_W-1:0] n;
  } rba_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [EIDX_W-1:0] spare_index;
    logic              is_primary;
  } rba_rsp_t;

endpackage

[rtl/replacement_block_allocator.sv]
// Top level of the replacement block allocator: handshakes, registers, control.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata: item fields, tuser: cmd
//  m_axis   out  m_axis_tvalid/tready       tdata: status, spare_index, is_primary
//  cfg      in   cfg_valid/cfg_ready        cfg_addr: register index, cfg_data
//
// One item at a time. A table write goes straight to the table engine, and an
// out-of-range replace straight to the result. An in-range replace takes two
// 32-bit quotients on the shared divider, then scans at most TABLE_DEPTH table
// entries, one per cycle, through the single read port. After reset the table
// is swept to free; no word is accepted then (cfg writes always are).
// A finished result sits in the output register; the next word is accepted
// while it waits, and only the completion of that next item waits for it.
module replacement_block_allocator import rba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH       = RBA_TABLE_DEPTH,
  parameter int unsigned ENTRIES_PER_BLOCK = RBA_ENTRIES_PER_BLOCK
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index[9:0], entry_code[11:10], entry_block[43:12], bad_block[75:44], zeros
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[1:0], spare_index[11:2], is_primary[12], zeros
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_addr,
  input  logic [31:0]           cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_DIV_BAD,
    T_DIV_DISK,
    T_MUL,
    T_ISSUE,
    T_SCAN,
    T_RESP
  } state_e;

  state_e             state_q;
  logic [BLK_W-1:0]   disk_q;
  logic [TRK_W-1:0]   track_q;
  logic [SPT_W-1:0]   spt_q;
  rba_req_t           req_q;
  logic [BLK_W-1:0]   qbad_q;
  rba_rsp_t           rsp_q;
  logic               out_valid_q;
  rba_rsp_t           out_q;

  logic               in_acc;
  logic [BLK_W-1:0]   in_bad;
  logic [TRK_W-1:0]   tsz;
  logic               div_start, div_done;
  logic [BLK_W-1:0]   div_dividend, div_quo;
  logic               scan_ready, scan_done;
  rba_rsp_t           scan_rsp;
  logic               out_free;

  assign in_bad    = s_axis_tdata[75:44];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign tsz       = (track_q == '0) ? TRK_W'(1) : track_q;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cfg_ready = 1'b1;

  // Divider: bad block first, then disk size, both by the track size
  assign div_start = (in_acc && (s_axis_tuser[0] == CMD_REPLACE) && (in_bad < disk_q)) ||
                     ((state_q == T_DIV_BAD) && div_done);
  assign div_dividend = (state_q == T_IDLE) ? in_bad : disk_q;

  rba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tsz),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rba_scan #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (state_q == T_ISSUE),
    .req_i       (req_q),
    .ready_o     (scan_ready),
    .done_o      (scan_done),
    .rsp_o       (scan_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q  <= '0;
      track_q <= TRK_W'(1);
      spt_q   <= SPT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_DISK_SIZE:  disk_q  <= cfg_data;
        CFG_TRACK_SIZE: track_q <= cfg_data[TRK_W-1:0];
        CFG_SPARES:     spt_q   <= cfg_data[SPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      req_q       <= '0;
      qbad_q      <= '0;
      rsp_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            req_q.is_write <= (s_axis_tuser[0] == CMD_WRITE);
            req_q.widx     <= s_axis_tdata[9:0];
            req_q.wcode    <= s_axis_tdata[11:10];
            req_q.wblock   <= s_axis_tdata[43:12];
            req_q.bad      <= in_bad;
            if (s_axis_tuser[0] == CMD_WRITE) begin
              state_q <= T_ISSUE;
            end else if (in_bad >= disk_q) begin
              rsp_q.status      <= ST_RANGE;
              rsp_q.spare_index <= '0;
              rsp_q.is_primary  <= 1'b0;
              state_q           <= T_RESP;
            end else begin
              state_q <= T_DIV_BAD;
            end
          end
        end
        T_DIV_BAD: begin
          if (div_done) begin
            qbad_q  <= div_quo;
            state_q <= T_DIV_DISK;
          end
        end
        T_DIV_DISK: begin
          if (div_done) begin
            state_q <= T_MUL;
          end
        end
        T_MUL: begin
          // primary spare and spare count; quotient stays in the divider
          req_q.prbn <= SPARE_W'(qbad_q) * SPARE_W'(spt_q);
          req_q.n    <= SPARE_W'(div_quo) * SPARE_W'(spt_q);
          state_q    <= T_ISSUE;
        end
        T_ISSUE: begin
          state_q <= T_SCAN;
        end
        T_SCAN: begin
          if (scan_done) begin
            rsp_q   <= scan_rsp;
            state_q <= T_RESP;
          end
        end
        T_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= rsp_q;
            state_q     <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == T_IDLE) && scan_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.is_primary, out_q.spare_index, out_q.status};

endmodule

[rtl/rba_div.sv]
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module rba_div import rba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BLK_W-1:0] dividend_i,
  input  logic [TRK_W-1:0] divisor_i,
  output logic             done_o,
  output logic [BLK_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(BLK_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TRK_W-1:0] rem_q, div_q;
  logic [BLK_W-1:0] quo_q;
  logic [TRK_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[BLK_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BLK_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TRK_W-1:0] : trial[TRK_W-1:0];
      quo_q <= {quo_q[BLK_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/rba_scan.sv]
// Spare table memory with clear pass, entry writes, scan and spare pick.
module rba_scan import rba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH       = RBA_TABLE_DEPTH,
  parameter int unsigned ENTRIES_PER_BLOCK = RBA_ENTRIES_PER_BLOCK
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  rba_req_t req_i,
  output logic     ready_o,
  output logic     done_o,
  output rba_rsp_t rsp_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BEND_W = $clog2(TABLE_DEPTH + ENTRIES_PER_BLOCK + 1);
  localparam int unsigned BOFF_W = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIFF,
    S_SEL
  } state_e;

  state_e             state_q;
  rba_req_t           req_q;
  logic [IDX_W-1:0]   clr_q;
  logic [CNT_W-1:0]   i_q;
  logic [BOFF_W-1:0]  boff_q;
  logic [BEND_W-1:0]  bend_q;
  logic               pv_q;
  logic [IDX_W-1:0]   pidx_q;
  logic               have_low_q, have_high_q;
  logic [IDX_W-1:0]   low_q, high_q;
  logic [SPARE_W-1:0] dlow_q, dhigh_q;
  logic               done_q;
  rba_rsp_t           rsp_q;

  rba_entry_t         mem_q [TABLE_DEPTH];
  rba_entry_t         rd_q;
  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  rba_entry_t         wdata;

  logic               go, mark, is_free, below, pick_low, wr_ok;
  logic [IDX_W-1:0]   pick;

  // Issue the next entry while inside the table and inside a whole covered block
  assign go = (i_q < CNT_W'(TABLE_DEPTH)) &&
              !((boff_q == '0) && (SPARE_W'(bend_q) > req_q.n));
  assign is_free  = (rd_q.code == CODE_FREE);
  assign below    = SPARE_W'(pidx_q) < req_q.prbn;
  assign mark     = pv_q && !is_free && (rd_q.owner == req_q.bad) &&
                    (rd_q.code != CODE_UNUSABLE);
  assign pick_low = have_low_q && (!have_high_q || (dlow_q < dhigh_q));
  assign pick     = pick_low ? low_q : high_q;
  assign wr_ok    = ({22'd0, req_i.widx} < 32'(TABLE_DEPTH));

  assign re    = (state_q == S_SCAN) && go;
  assign raddr = i_q[IDX_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        we          = req_valid_i && req_i.is_write && wr_ok;
        waddr       = IDX_W'(req_i.widx);
        wdata.code  = req_i.wcode;
        wdata.owner = req_i.wblock;
      end
      S_SEL: begin
        we          = have_low_q || have_high_q;
        waddr       = pick;
        wdata.code  = (SPARE_W'(pick) == req_q.prbn) ? CODE_PRIMARY : CODE_ALTERNATE;
        wdata.owner = req_q.bad;
      end
      default: begin
        // scan: retire a stale copy that still names the bad block
        we          = mark;
        waddr       = pidx_q;
        wdata.code  = CODE_UNUSABLE;
        wdata.owner = rd_q.owner;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      i_q         <= '0;
      boff_q      <= '0;
      bend_q      <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      have_low_q  <= 1'b0;
      have_high_q <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      dlow_q      <= '0;
      dhigh_q     <= '0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
      req_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (pv_q && is_free) begin
        if (below) begin
          low_q      <= pidx_q;
          have_low_q <= 1'b1;
        end else if (!have_high_q) begin
          high_q      <= pidx_q;
          have_high_q <= 1'b1;
        end
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid_i) begin
            req_q <= req_i;
            if (req_i.is_write) begin
              rsp_q  <= '0;
              done_q <= 1'b1;
            end else begin
              i_q         <= '0;
              boff_q      <= '0;
              bend_q      <= BEND_W'(ENTRIES_PER_BLOCK);
              have_low_q  <= 1'b0;
              have_high_q <= 1'b0;
              state_q     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pv_q   <= go;
          pidx_q <= raddr;
          if (go) begin
            i_q <= i_q + 1'b1;
            if (boff_q == BOFF_W'(ENTRIES_PER_BLOCK - 1)) begin
              boff_q <= '0;
              bend_q <= bend_q + BEND_W'(ENTRIES_PER_BLOCK);
            end else begin
              boff_q <= boff_q + 1'b1;
            end
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          dlow_q  <= req_q.prbn - SPARE_W'(low_q);
          dhigh_q <= SPARE_W'(high_q) - req_q.prbn;
          state_q <= S_SEL;
        end
        S_SEL: begin
          if (have_low_q || have_high_q) begin
            rsp_q.status      <= ST_OK;
            rsp_q.spare_index <= EIDX_W'(pick);
            rsp_q.is_primary  <= (SPARE_W'(pick) == req_q.prbn);
          end else begin
            rsp_q.status      <= ST_NO_SPARE;
            rsp_q.spare_index <= '0;
            rsp_q.is_primary  <= 1'b0;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

endmodule

[rtl/rba_checker.sv]
// Port-level checks of the replacement block allocator, bound to the top level.
module rba_checker import rba_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Status is one of ok, out of range, no free spare
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] <= ST_NO_SPARE)
    else $error("undefined status code");

  // A failed replace reports no spare
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[12:2] == 11'd0)
    else $error("spare reported with failing status");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

endmodule

bind replacement_block_allocator rba_checker u_rba_checker (.*);

[sim/replacement_block_allocator_tb.sv]
// Self-checking testbench of the replacement block allocator: spare-table predictor, scoreboard.
`timescale 1ns / 100ps

import rba_pkg::*;

typedef struct {
  rba_cmd_e    cmd;
  logic [9:0]  idx;
  rba_code_e   code;
  logic [31:0] blk;
  logic [31:0] bad;
} rba_item_t;

// Mirror of the spare table; predicts each reply and checks the ones the block sends.
class spare_alloc_sb;
  rba_code_e   code_of [RBA_TABLE_DEPTH];
  logic [31:0] owner_of [RBA_TABLE_DEPTH];
  logic [31:0] disk_blocks;
  logic [15:0] trk_blocks;
  logic [7:0]  trk_spares;
  rba_rsp_t    pending_replies [$];
  int          errors;

  function new();
    foreach (code_of[i]) begin
      code_of[i]  = CODE_FREE;
      owner_of[i] = '0;
    end
    disk_blocks = '0;
    trk_blocks  = 16'd1;
    trk_spares  = 8'd1;
    errors      = 0;
  endfunction

  function void set_reg(rba_cfg_e addr, logic [31:0] val);
    case (addr)
      CFG_DISK_SIZE:  disk_blocks = val;
      CFG_TRACK_SIZE: trk_blocks  = val[15:0];
      CFG_SPARES:     trk_spares  = val[7:0];
      default: ;
    endcase
  endfunction

  function longint unsigned eff_track();
    return (trk_blocks == 0) ? 1 : trk_blocks;
  endfunction

  // Entries covered by whole table blocks, capped at the table depth
  function longint unsigned scan_span();
    longint unsigned n;
    n = (longint'(disk_blocks) / eff_track()) * trk_spares;
    n = (n / RBA_ENTRIES_PER_BLOCK) * RBA_ENTRIES_PER_BLOCK;
    return (n > RBA_TABLE_DEPTH) ? RBA_TABLE_DEPTH : n;
  endfunction

  // Word accepted on the input side: update the table and queue the reply
  function void note_word(rba_item_t it);
    rba_rsp_t        r;
    longint unsigned bad64, home, span, below, above, pick;
    bit              have_below, have_above;
    r = '0;
    bad64 = it.bad;
    have_below = 1'b0;
    have_above = 1'b0;
    below = 0;
    above = 0;
    if (it.cmd == CMD_WRITE) begin
      code_of[it.idx]  = it.code;
      owner_of[it.idx] = it.blk;
    end else if (it.bad >= disk_blocks) begin
      r.status = ST_RANGE;
    end else begin
      home = (bad64 / eff_track()) * trk_spares;
      span = scan_span();
      for (longint unsigned i = 0; i < span; i++) begin
        if (code_of[i] == CODE_FREE) begin
          if (i < home) begin
            below = i;
            have_below = 1'b1;
          end else if (!have_above) begin
            above = i;
            have_above = 1'b1;
          end
        end else if (owner_of[i] == it.bad && code_of[i] != CODE_UNUSABLE) begin
          // stale mapping of the same block gets retired
          code_of[i] = CODE_UNUSABLE;
        end
      end
      if (!have_below && !have_above) begin
        r.status = ST_NO_SPARE;
      end else begin
        if (!have_below) pick = above;
        else if (!have_above) pick = below;
        else if (home - below < above - home) pick = below;
        else pick = above;  // ties go up
        r.status = ST_OK;
        r.spare_index = pick[9:0];
        r.is_primary = (pick == home);
        if (pick == home) code_of[pick] = CODE_PRIMARY;
        else code_of[pick] = CODE_ALTERNATE;
        owner_of[pick] = it.bad;
      end
    end
    pending_replies.push_back(r);
  endfunction

  function void check_reply(logic [15:0] word);
    rba_rsp_t got, want;
    got.status      = word[1:0];
    got.spare_index = word[11:2];
    got.is_primary  = word[12];
    if (pending_replies.size() == 0) begin
      $display("%0t: reply %h arrived with nothing pending", $time, word);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.spare_index !== want.spare_index) begin
      $display("%0t: spare_index expected %0d actual %0d", $time, want.spare_index,
               got.spare_index);
      errors++;
    end
    if (got.is_primary !== want.is_primary) begin
      $display("%0t: is_primary expected %0d actual %0d", $time, want.is_primary,
               got.is_primary);
      errors++;
    end
  endfunction
endclass

module replacement_block_allocator_tb;

  // Longest quiet stretch: reset sweep or a full scan plus stalls, with wide margin
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_TAIL     = 40;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // entry_index[9:0], entry_code[11:10], entry_block[43:12], bad_block[75:44], zeros
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // cmd[0]
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status[1:0], spare_index[11:2], is_primary[12], zeros
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_addr      = '0;
  logic [31:0]           cfg_data      = '0;

  spare_alloc_sb sb = new();

  logic [31:0] recent_bad [$];  // pool of replaced blocks, reused as owners and repeats
  int          in_calm  = 0;
  int          out_calm = 0;
  int          idle_cycles = 0;

  replacement_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random wait before each word, with occasional runs of back-to-back words
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  // Called at a rising edge; leaves tvalid high at the accepting edge
  task automatic send_word(input rba_item_t it);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {4'b0, it.bad, it.blk, it.code, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(it);
  endtask

  // Random filler in the fields the command does not use
  function automatic rba_item_t noise_word();
    rba_item_t it;
    it.cmd  = CMD_WRITE;
    it.idx  = 10'($urandom_range(0, 1023));
    it.code = rba_code_e'($urandom_range(0, 3));
    it.blk  = $urandom;
    it.bad  = $urandom;
    return it;
  endfunction

  task automatic put_write(input logic [9:0] idx, input rba_code_e code,
                           input logic [31:0] blk);
    rba_item_t it;
    it      = noise_word();
    it.cmd  = CMD_WRITE;
    it.idx  = idx;
    it.code = code;
    it.blk  = blk;
    send_word(it);
  endtask

  task automatic put_replace(input logic [31:0] bad);
    rba_item_t it;
    it     = noise_word();
    it.cmd = CMD_REPLACE;
    it.bad = bad;
    send_word(it);
  endtask

  // Random word biased toward the scanned part of the table and reachable spares
  function automatic rba_item_t rand_word();
    rba_item_t       it;
    longint unsigned span, disk, near_lim, spt;
    int              pick;
    it   = noise_word();
    span = sb.scan_span();
    disk = sb.disk_blocks;
    spt  = (sb.trk_spares == 0) ? 1 : sb.trk_spares;
    if ($urandom_range(0, 99) < 50) begin
      it.cmd = CMD_WRITE;
      if (span > 0 && $urandom_range(0, 3) != 0)
        it.idx = 10'($urandom_range(0, 32'(span - 1)));
      if ($urandom_range(0, 1) == 1) it.code = CODE_FREE;
      if (recent_bad.size() > 0 && $urandom_range(0, 1) == 1)
        it.blk = recent_bad[$urandom_range(0, recent_bad.size() - 1)];
    end else begin
      it.cmd = CMD_REPLACE;
      pick = $urandom_range(0, 9);
      if (pick < 7 && disk > 0) begin
        if (pick < 2 && recent_bad.size() > 0) begin
          it.bad = recent_bad[$urandom_range(0, recent_bad.size() - 1)];
        end else begin
          // keep the home spare near the table most of the time
          near_lim = (RBA_TABLE_DEPTH / spt + 2) * sb.eff_track();
          if (near_lim > disk || $urandom_range(0, 3) == 0) near_lim = disk;
          it.bad = 32'($urandom % near_lim);
        end
      end else if (pick < 9) begin
        it.bad = (disk == 64'hFFFF_FFFF) ? 32'hFFFF_FFFF :
                 $urandom_range(32'hFFFF_FFFF, disk[31:0]);
      end
      recent_bad.push_back(it.bad);
      if (recent_bad.size() > 16) void'(recent_bad.pop_front());
    end
    return it;
  endfunction

  // Hold the sender until every queued reply is back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_replies.size() != 0);
  endtask

  task automatic write_regs(input logic [31:0] disk, input logic [15:0] tsz,
                            input logic [7:0] spt);
    logic [31:0] vals [3];
    rba_cfg_e    addrs [3];
    addrs = '{CFG_DISK_SIZE, CFG_TRACK_SIZE, CFG_SPARES};
    vals  = '{disk, {16'b0, tsz}, {24'b0, spt}};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= addrs[k];
      cfg_data  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready);
      sb.set_reg(addrs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n_words);
    for (int k = 0; k < n_words; k++) begin
      if (n_words >= 60 && k == n_words / 2) drain_replies();
      send_word(rand_word());
    end
  endtask

  task automatic run_phase(input logic [31:0] disk, input logic [15:0] tsz,
                           input logic [7:0] spt, input int n_words);
    drain_replies();
    write_regs(disk, tsz, spt);
    run_random(n_words);
  endtask

  // Receiver: random backpressure, every accepted reply goes to the scoreboard
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_reply(m_axis_tdata);
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero disk size, so every replace is out of range
    put_replace(32'h0);
    put_replace(32'hFFFF_FFFF);
    put_write(10'd1023, CODE_UNUSABLE, 32'hFFFF_FFFF);
    put_write(10'd0, CODE_FREE, 32'h0);

    // 128 scanned entries, home spare = block / 10
    drain_replies();
    write_regs(32'd1500, 16'd10, 8'd1);
    put_replace(32'd1499);   // home beyond the scan, last free below wins
    put_replace(32'd1500);   // first block out of range
    put_replace(32'd0);      // home spare free: primary
    put_replace(32'd0);      // same block again: old mapping retired, neighbor taken
    put_write(10'd10, CODE_ALTERNATE, 32'd7777);
    put_replace(32'd100);    // equal distance both ways, upper one taken
    put_write(10'd21, CODE_PRIMARY, 32'd999);
    put_write(10'd22, CODE_ALTERNATE, 32'd999);
    put_replace(32'd210);    // lower free entry is nearer
    put_replace(32'd999);    // both entries owned by 999 become unusable
    put_write(10'd21, CODE_FREE, 32'd0);
    put_write(10'd30, CODE_UNUSABLE, 32'd300);
    put_replace(32'd300);    // unusable entry with the same owner stays as is
    put_write(10'd0, CODE_FREE, 32'hFFFF_FFFF);

    // Zero track size acts as one; zero spares leaves nothing to scan
    drain_replies();
    write_regs(32'd3000, 16'd0, 8'd0);
    put_replace(32'd0);
    put_replace(32'd2999);
    put_replace(32'd3000);
    run_random(25);

    run_phase(32'd1024, 16'd1, 8'd1, 135);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 80);
    run_phase(32'd4096, 16'd16, 8'd8, 100);
    run_phase(32'd200000, 16'hFFFF, 8'hFF, 80);
    run_phase(32'd2000, 16'd3, 8'd2, 60);
    run_phase(32'd500, 16'd1, 8'hFF, 40);

    drain_replies();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
